// ===== hw/rtl/mrds_pkg.sv =====
// Shared constants, register indexes and a helper for the mixed-radix digit splitter.
package mrds_pkg;

    localparam int JOB_W          = 63;
    localparam int WORK_W         = 64;
    localparam int DIGIT_W        = 8;
    localparam int RADIX_W        = 8;
    localparam int ERADIX_W       = 9;
    localparam int POS_W          = 3;
    localparam int BITS_PER_STAGE = 8;
    localparam int STAGES_PER_POS = WORK_W / BITS_PER_STAGE;
    localparam int NUM_RADIX_REGS = 6;
    localparam int MAX_POSITIONS_DEF = 6;
    localparam int S_TDATA_W      = 64;
    localparam int M_TDATA_W      = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INCLUDE_EMPTY = 3'd0,
        REG_NUM_POSITIONS = 3'd1,
        REG_RADIX_0       = 3'd2,
        REG_RADIX_1       = 3'd3,
        REG_RADIX_2       = 3'd4,
        REG_RADIX_3       = 3'd5,
        REG_RADIX_4       = 3'd6,
        REG_RADIX_5       = 3'd7
    } cfg_reg_t;

    // radix + empty choice; a zero sum behaves as one
    function automatic logic [ERADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] radix,
                                                     input logic inc_empty);
        logic [ERADIX_W-1:0] r;
        r = {1'b0, radix} + {{(ERADIX_W-1){1'b0}}, inc_empty};
        if (r == '0) begin
            r = ERADIX_W'(1);
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/mrds_div_stage.sv =====
// One pipeline stage of long division: eight quotient bits against a narrow radix.
module mrds_div_stage #(
    parameter int MAX_POSITIONS = mrds_pkg::MAX_POSITIONS_DEF,
    parameter int POS           = 0,
    parameter int SUB           = 0
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      en,
    input  logic [mrds_pkg::ERADIX_W-1:0]             rdx,
    input  logic                                      in_valid,
    input  logic [mrds_pkg::WORK_W-1:0]               in_work,
    input  logic [mrds_pkg::DIGIT_W-1:0]              in_rem,
    input  logic [MAX_POSITIONS*mrds_pkg::DIGIT_W-1:0] in_digits,
    output logic                                      out_valid,
    output logic [mrds_pkg::WORK_W-1:0]               out_work,
    output logic [mrds_pkg::DIGIT_W-1:0]              out_rem,
    output logic [MAX_POSITIONS*mrds_pkg::DIGIT_W-1:0] out_digits
);

    localparam int DW = MAX_POSITIONS * mrds_pkg::DIGIT_W;

    logic                          valid_reg;
    logic [mrds_pkg::WORK_W-1:0]   work_reg,   work_next;
    logic [mrds_pkg::DIGIT_W-1:0]  rem_reg,    rem_next;
    logic [DW-1:0]                 digits_reg, digits_next;

    always_comb begin
        logic [mrds_pkg::WORK_W-1:0]   w;
        logic [mrds_pkg::DIGIT_W-1:0]  r;
        logic [mrds_pkg::ERADIX_W-1:0] t;
        w = in_work;
        // a new division starts with an empty partial remainder
        r = (SUB == 0) ? '0 : in_rem;
        t = '0;
        for (int i = 0; i < mrds_pkg::BITS_PER_STAGE; i++) begin
            t = {r, w[mrds_pkg::WORK_W-1]};
            w = {w[mrds_pkg::WORK_W-2:0], 1'b0};
            if (t >= rdx) begin
                t    = t - rdx;
                w[0] = 1'b1;
            end
            // t < rdx <= 256, fits the digit width
            r = t[mrds_pkg::DIGIT_W-1:0];
        end
        work_next   = w;
        rem_next    = r;
        digits_next = in_digits;
        if (SUB == mrds_pkg::STAGES_PER_POS - 1) begin
            digits_next[POS*mrds_pkg::DIGIT_W +: mrds_pkg::DIGIT_W] = r;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            work_reg   <= work_next;
            rem_reg    <= rem_next;
            digits_reg <= digits_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_work   = work_reg;
    assign out_rem    = rem_reg;
    assign out_digits = digits_reg;

endmodule

// ===== hw/rtl/mrds_digit_out.sv =====
// Output stage: holds one finished job and emits its digits one transaction at a time.
module mrds_digit_out #(
    parameter int MAX_POSITIONS = mrds_pkg::MAX_POSITIONS_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       in_valid,
    input  logic [MAX_POSITIONS*mrds_pkg::DIGIT_W-1:0] in_digits,
    input  logic [mrds_pkg::POS_W-1:0]                 cnt,
    output logic                                       take_new,
    input  logic                                       m_tready,
    output logic                                       m_tvalid,
    output logic [mrds_pkg::POS_W-1:0]                 m_pos,
    output logic [mrds_pkg::DIGIT_W-1:0]               m_word,
    output logic                                       m_last
);

    localparam int DW = MAX_POSITIONS * mrds_pkg::DIGIT_W;

    logic                        busy_reg;
    logic [mrds_pkg::POS_W-1:0]  pos_reg;
    logic [DW-1:0]               digits_reg;
    logic                        is_last;

    assign is_last  = (pos_reg == cnt - mrds_pkg::POS_W'(1));
    // reload in the same cycle the final digit goes out
    assign take_new = !busy_reg || (m_tready && is_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end else if (take_new) begin
            busy_reg <= in_valid;
            pos_reg  <= '0;
        end else if (m_tready) begin
            pos_reg  <= pos_reg + mrds_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (take_new) begin
            digits_reg <= in_digits;
        end else if (m_tready) begin
            digits_reg <= digits_reg >> mrds_pkg::DIGIT_W;
        end
    end

    assign m_tvalid = busy_reg;
    assign m_pos    = pos_reg;
    assign m_word   = digits_reg[mrds_pkg::DIGIT_W-1:0];
    assign m_last   = is_last;

endmodule

// ===== hw/rtl/mixed_radix_digit_split.sv =====
// Pipeline: 8*MAX_POSITIONS divider stages plus one output register lie between an
// input transaction and its first digit.
// Throughput: a job enters every cycle unless the pipe stalls; the output emits one digit
// per cycle while m_tready is high, so a job's num_positions digits (up to 6 at the default) set the sustained rate.
// Reset: aresetn clears all valid bits and sets the config registers to their defaults.
module mixed_radix_digit_split #(
    parameter int MAX_POSITIONS = mrds_pkg::MAX_POSITIONS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [mrds_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mrds_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mrds_pkg::S_TDATA_W-1:0]   s_tdata,  // [62:0] job_number
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mrds_pkg::M_TDATA_W-1:0]   m_tdata,  // [2:0] position, [10:3] word_index
    output logic                             m_tlast
);

    localparam int NST = MAX_POSITIONS * mrds_pkg::STAGES_PER_POS;
    localparam int DW  = MAX_POSITIONS * mrds_pkg::DIGIT_W;

    logic                          include_empty_reg;
    logic [mrds_pkg::POS_W-1:0]    num_positions_reg;
    logic [mrds_pkg::RADIX_W-1:0]  radix_reg [mrds_pkg::NUM_RADIX_REGS];
    logic [mrds_pkg::ERADIX_W-1:0] eff_rdx   [MAX_POSITIONS];
    logic [mrds_pkg::POS_W-1:0]    cnt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            include_empty_reg <= 1'b0;
            num_positions_reg <= mrds_pkg::POS_W'(1);
            for (int i = 0; i < mrds_pkg::NUM_RADIX_REGS; i++) begin
                radix_reg[i] <= mrds_pkg::RADIX_W'(1);
            end
        end else if (cfg_wr_en) begin
            if (cfg_index == mrds_pkg::REG_INCLUDE_EMPTY) begin
                include_empty_reg <= cfg_data[0];
            end
            if (cfg_index == mrds_pkg::REG_NUM_POSITIONS) begin
                num_positions_reg <= cfg_data[mrds_pkg::POS_W-1:0];
            end
            for (int i = 0; i < mrds_pkg::NUM_RADIX_REGS; i++) begin
                if (cfg_index == mrds_pkg::CFG_IDX_W'(int'(mrds_pkg::REG_RADIX_0) + i)) begin
                    radix_reg[i] <= cfg_data[mrds_pkg::RADIX_W-1:0];
                end
            end
        end
    end

    always_comb begin
        for (int p = 0; p < MAX_POSITIONS; p++) begin
            eff_rdx[p] = mrds_pkg::eff_radix(radix_reg[p], include_empty_reg);
        end
        // zero counts as one position, larger counts saturate
        cnt = num_positions_reg;
        if (cnt == '0) begin
            cnt = mrds_pkg::POS_W'(1);
        end else if (cnt > mrds_pkg::POS_W'(MAX_POSITIONS)) begin
            cnt = mrds_pkg::POS_W'(MAX_POSITIONS);
        end
    end

    logic [NST:0]                           valid_c;
    logic [NST:0][mrds_pkg::WORK_W-1:0]     work_c;
    logic [NST:0][mrds_pkg::DIGIT_W-1:0]    rem_c;
    logic [NST:0][DW-1:0]                   digits_c;
    logic                                   take_new;
    logic                                   en;
    logic [mrds_pkg::POS_W-1:0]             out_pos;
    logic [mrds_pkg::DIGIT_W-1:0]           out_word;

    // whole pipe advances unless its last stage holds a job the output cannot take
    assign en       = take_new || !valid_c[NST];
    assign s_tready = en;

    assign valid_c[0]  = s_tvalid;
    assign work_c[0]   = {1'b0, s_tdata[mrds_pkg::JOB_W-1:0]};
    assign rem_c[0]    = '0;
    assign digits_c[0] = '0;

    for (genvar k = 0; k < NST; k++) begin : g_stage
        mrds_div_stage #(
            .MAX_POSITIONS(MAX_POSITIONS),
            .POS          (k / mrds_pkg::STAGES_PER_POS),
            .SUB          (k % mrds_pkg::STAGES_PER_POS)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .rdx       (eff_rdx[k / mrds_pkg::STAGES_PER_POS]),
            .in_valid  (valid_c[k]),
            .in_work   (work_c[k]),
            .in_rem    (rem_c[k]),
            .in_digits (digits_c[k]),
            .out_valid (valid_c[k+1]),
            .out_work  (work_c[k+1]),
            .out_rem   (rem_c[k+1]),
            .out_digits(digits_c[k+1])
        );
    end

    mrds_digit_out #(
        .MAX_POSITIONS(MAX_POSITIONS)
    ) u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (valid_c[NST]),
        .in_digits(digits_c[NST]),
        .cnt      (cnt),
        .take_new (take_new),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_pos    (out_pos),
        .m_word   (out_word),
        .m_last   (m_tlast)
    );

    assign m_tdata = {{(mrds_pkg::M_TDATA_W - mrds_pkg::DIGIT_W - mrds_pkg::POS_W){1'b0}},
                      out_word, out_pos};

`ifndef SYNTHESIS
    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output stage is empty");

    a_first_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !$past(m_tvalid)) |-> (m_tdata[mrds_pkg::POS_W-1:0] == '0))
        else $error("job did not start at position zero");

    a_pos_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
        (m_tvalid && m_tdata[mrds_pkg::POS_W-1:0] ==
         $past(m_tdata[mrds_pkg::POS_W-1:0]) + mrds_pkg::POS_W'(1)))
        else $error("position did not advance by one within a job");
`endif

endmodule

// ===== tb/mixed_radix_digit_split_tb.sv =====
// Self-checking testbench for the mixed-radix digit splitter: scoreboard class plus stream drivers.
module mixed_radix_digit_split_tb;
    import mrds_pkg::*;

    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 60;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_JOBS    = 60;
    localparam int IDLE_PCT      = 36;

    typedef struct {
        logic [POS_W-1:0]   position;
        logic [DIGIT_W-1:0] word_index;
        logic               last_digit;
    } digit_t;

    class digit_scoreboard;
        bit                include_empty;
        bit [2:0]          num_positions;
        bit [RADIX_W-1:0]  radix[NUM_RADIX_REGS];
        digit_t            expected_digits[$];
        int                errors;
        int                jobs_seen;
        int                digits_seen;

        function new();
            include_empty = 1'b0;
            num_positions = 3'd1;
            foreach (radix[i]) radix[i] = 8'd1;
            errors = 0;
            jobs_seen = 0;
            digits_seen = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_INCLUDE_EMPTY: include_empty = val[0];
                REG_NUM_POSITIONS: num_positions = val[2:0];
                default:           radix[idx - REG_RADIX_0] = val;
            endcase
        endfunction

        function int pending();
            return expected_digits.size();
        endfunction

        // split one job number into its expected digits
        function void note_job(logic [JOB_W-1:0] job);
            logic [WORK_W-1:0]   quotient;
            logic [ERADIX_W-1:0] base;
            int                  count;
            digit_t              d;
            count = num_positions;
            if (count == 0) count = 1;
            if (count > MAX_POSITIONS_DEF) count = MAX_POSITIONS_DEF;
            quotient = {1'b0, job};
            for (int p = 0; p < count; p++) begin
                base = {1'b0, radix[p]} + ERADIX_W'(include_empty);
                if (base == '0) base = ERADIX_W'(1);
                d.position   = POS_W'(p);
                d.word_index = DIGIT_W'(quotient % base);
                d.last_digit = (p == count - 1);
                quotient     = quotient / base;
                expected_digits.push_back(d);
            end
            jobs_seen++;
        endfunction

        function void check_digit(logic [POS_W-1:0] pos, logic [DIGIT_W-1:0] widx,
                                  logic last);
            digit_t exp_d;
            digits_seen++;
            if (expected_digits.size() == 0) begin
                $display("%0t: unexpected digit pos=%0d index=%0d last=%0b",
                         $time, pos, widx, last);
                errors++;
                return;
            end
            exp_d = expected_digits.pop_front();
            if (pos !== exp_d.position) begin
                $display("%0t: position mismatch expected %0d actual %0d",
                         $time, exp_d.position, pos);
                errors++;
            end
            if (widx !== exp_d.word_index) begin
                $display("%0t: word_index mismatch at pos %0d expected %0d actual %0d",
                         $time, exp_d.position, exp_d.word_index, widx);
                errors++;
            end
            if (last !== exp_d.last_digit) begin
                $display("%0t: last_digit mismatch at pos %0d expected %0b actual %0b",
                         $time, exp_d.position, exp_d.last_digit, last);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;  // [62:0] job_number
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // [2:0] position, [10:3] word_index
    logic                  m_tlast;

    bit sender_idle   = 1'b1;
    bit sink_idle     = 1'b1;
    bit hold_off_req  = 1'b0;
    int config_count  = 0;

    digit_scoreboard sb = new();

    mixed_radix_digit_split u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_digit(m_tdata[2:0], m_tdata[10:3], m_tlast);
        end
    end

    // result-side ready: random, always-on, or one long hold-off
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
            end else if (sink_idle) begin
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_config(input bit empty, input logic [2:0] npos,
                              input logic [7:0] r0, input logic [7:0] r1,
                              input logic [7:0] r2, input logic [7:0] r3,
                              input logic [7:0] r4, input logic [7:0] r5);
        write_reg(REG_INCLUDE_EMPTY, {7'd0, empty});
        write_reg(REG_NUM_POSITIONS, {5'd0, npos});
        write_reg(REG_RADIX_0, r0);
        write_reg(REG_RADIX_1, r1);
        write_reg(REG_RADIX_2, r2);
        write_reg(REG_RADIX_3, r3);
        write_reg(REG_RADIX_4, r4);
        write_reg(REG_RADIX_5, r5);
        config_count++;
    endtask

    task automatic send_job(input logic [JOB_W-1:0] job);
        if (sender_idle) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, job};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_job(job);
        @(negedge aclk);
    endtask

    // drop valid and wait for every outstanding digit
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
    endtask

    function automatic logic [7:0] pick_radix();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd255;
            3:       return 8'd254;
            4:       return 8'($urandom_range(2, 16));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [JOB_W-1:0] pick_job();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0:       return JOB_W'(raw);
            1:       return JOB_W'(raw[15:0]);
            2:       return '1;
            3:       return '0;
            default: return JOB_W'(raw >> $urandom_range(0, 63));
        endcase
    endfunction

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset defaults: one position of radix 1, every digit is zero
        send_job('0);
        send_job('1);
        send_job(63'd12345);
        wait_drained();

        // wide radices plus a zero radix without the empty option
        set_config(1'b0, 3'd6, 8'd255, 8'd254, 8'd0, 8'd1, 8'd2, 8'd17);
        send_job('0);
        send_job('1);
        send_job(63'hFF);
        send_job(63'h5555_5555_5555_5555);
        send_job(63'h2AAA_AAAA_AAAA_AAAA);
        wait_drained();

        // empty option on, position count above the maximum saturates
        set_config(1'b1, 3'd7, 8'd255, 8'd0, 8'd3, 8'd254, 8'd1, 8'd9);
        send_job('1);
        send_job(63'd255);
        send_job(63'd256);
        send_job('0);
        wait_drained();

        // position count zero acts as one
        set_config(1'b0, 3'd0, 8'd10, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5);
        send_job(63'd9);
        send_job(63'd10);
        send_job('1);
        wait_drained();

        // radix 256 at each of the three positions: digits are the low three bytes of the job
        set_config(1'b1, 3'd3, 8'd255, 8'd255, 8'd255, 8'd1, 8'd1, 8'd1);
        send_job(63'hFF_FFFF);
        send_job(63'h100_0000);
        send_job(63'h12_3456);
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            set_config(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                       pick_radix(), pick_radix(), pick_radix(),
                       pick_radix(), pick_radix(), pick_radix());
            sender_idle = (ph != 0);
            sink_idle   = (ph != 0);
            if (ph == 2) hold_off_req = 1'b1;
            for (int k = 0; k < PHASE_JOBS; k++) begin
                if (ph == 4 && k == PHASE_JOBS / 2) wait_drained();
                send_job(pick_job());
            end
            wait_drained();
        end

        sink_idle = 1'b1;
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("covered %0d jobs and %0d digits over %0d register settings",
                 sb.jobs_seen, sb.digits_seen, config_count);
        $display("(empty option, saturated and zero position counts, zero and 256 radices)");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/mrds_pkg.sv
hw/rtl/mrds_div_stage.sv
hw/rtl/mrds_digit_out.sv
hw/rtl/mixed_radix_digit_split.sv
tb/mixed_radix_digit_split_tb.sv
